>>> src/gyro_zero_rate_calibrate_deadzone_defines.svh
// Assertion macros used by the gyro calibration top module
`ifndef GYRO_ZERO_RATE_CALIBRATE_DEADZONE_DEFINES_SVH
`define GYRO_ZERO_RATE_CALIBRATE_DEADZONE_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define GZRC_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: check failed");

// next-cycle implication, disabled while in reset
`define GZRC_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: check failed");

`endif

>>> src/gzrc_pkg.sv
package gzrc_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int SUM_W     = 24;
  localparam int CAL_COUNT = 128;
  localparam int CNT_W     = $clog2(CAL_COUNT);
  // floor(log2(CAL_COUNT))
  localparam int SUM_SHIFT = $clog2(CAL_COUNT + 1) - 1;

  typedef enum logic {
    OP_CAL  = 1'b0,
    OP_MEAS = 1'b1
  } op_t;

  typedef struct packed {
    op_t                        operation;
    logic signed [SAMPLE_W-1:0] x_raw;
    logic signed [SAMPLE_W-1:0] y_raw;
    logic signed [SAMPLE_W-1:0] z_raw;
  } in_req_t;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_out;
    logic signed [SAMPLE_W-1:0] y_out;
    logic signed [SAMPLE_W-1:0] z_out;
    logic                       calibrated;
    logic                       round_done;
  } out_req_t;

  // per-item control from the sequencer to each axis slice
  typedef struct packed {
    logic cal_en;  // calibration request advancing this cycle
    logic meas;    // request is a measurement
    logic clear;   // first sample of a round
    logic done;    // sample completes the round
  } axis_ctl_t;

endpackage

>>> src/gyro_zero_rate_calibrate_deadzone.sv
// Channel | Ports                         | Direction | Request
// input   | in_valid, in_stall, in_req    | in        | in_req_t: op, x/y/z raw
// result  | out_valid, out_stall, out_req | out       | out_req_t: x/y/z, flags
//
// One request per cycle sustained unless the result stalls; input register,
// then result register, the per-axis add/compare/subtract sitting between them.
// Synchronous active-low reset clears sums, maxima, offsets, round count and
// the calibrated flag.
// A stalled result holds the result register; an occupied input register then
// holds too and in_stall rises in the same cycle.
`include "gyro_zero_rate_calibrate_deadzone_defines.svh"
module gyro_zero_rate_calibrate_deadzone
  import gzrc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  in_req_t  in_req,
  output logic     out_valid,
  input  logic     out_stall,
  output out_req_t out_req
);

  logic             s1_valid_r;
  in_req_t          s1_req_r;
  logic             out_valid_r;
  out_req_t         out_req_r, out_req_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W:0]   cnt_inc;
  logic             cal_flag_r, cal_flag_nxt;
  logic             advance, is_cal, done;
  axis_ctl_t        ctl;
  logic signed [SAMPLE_W-1:0] x_res, y_res, z_res;

  assign advance  = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !advance;
  assign is_cal   = (s1_req_r.operation == OP_CAL);
  assign cnt_inc  = {1'b0, cnt_r} + (CNT_W+1)'(1);
  assign done     = is_cal && (cnt_inc >= (CNT_W+1)'(CAL_COUNT));

  always_comb begin
    ctl.cal_en = advance && is_cal;
    ctl.meas   = !is_cal;
    ctl.clear  = (cnt_r == '0);
    ctl.done   = done;
  end

  always_comb begin
    cnt_nxt      = cnt_r;
    cal_flag_nxt = cal_flag_r;
    if (is_cal) begin
      cnt_nxt = done ? '0 : cnt_inc[CNT_W-1:0];
      if (done) begin
        cal_flag_nxt = 1'b1;
      end
    end
    out_req_nxt.x_out      = x_res;
    out_req_nxt.y_out      = y_res;
    out_req_nxt.z_out      = z_res;
    out_req_nxt.calibrated = cal_flag_nxt;
    out_req_nxt.round_done = done;
  end

  gzrc_axis u_axis_x (.clk(clk), .rst_n(rst_n), .ctl(ctl), .raw(s1_req_r.x_raw), .res(x_res));
  gzrc_axis u_axis_y (.clk(clk), .rst_n(rst_n), .ctl(ctl), .raw(s1_req_r.y_raw), .res(y_res));
  gzrc_axis u_axis_z (.clk(clk), .rst_n(rst_n), .ctl(ctl), .raw(s1_req_r.z_raw), .res(z_res));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      cnt_r       <= '0;
      cal_flag_r  <= 1'b0;
    end else begin
      // take a new request whenever the input register is free or moving on
      if (!in_stall) begin
        s1_valid_r <= in_valid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        cnt_r       <= cnt_nxt;
        cal_flag_r  <= cal_flag_nxt;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_req_r <= in_req;
    end
    if (advance) begin
      out_req_r <= out_req_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_req   = out_req_r;

  `GZRC_ASSERT_IMP(a_done_flags_cal, out_valid_r && out_req_r.round_done, out_req_r.calibrated)
  `GZRC_ASSERT_IMP(a_no_stall_empty, !out_valid_r, !in_stall)
  `GZRC_ASSERT_NXT(a_done_wraps_cnt, advance && done, cnt_r == '0)
  `GZRC_ASSERT_NXT(a_flag_sticky, cal_flag_r, cal_flag_r)

endmodule

>>> src/gzrc_axis.sv
module gzrc_axis
  import gzrc_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst_n,
  input  axis_ctl_t                  ctl,
  input  logic signed [SAMPLE_W-1:0] raw,
  output logic signed [SAMPLE_W-1:0] res
);

  logic signed [SUM_W-1:0]    sum_r, sum_nxt, sum_base, sum_shr;
  logic signed [SAMPLE_W-1:0] max_r, max_nxt, max_base;
  logic signed [SAMPLE_W-1:0] off_r, off_nxt;
  logic signed [SAMPLE_W-1:0] diff;
  logic signed [SAMPLE_W:0]   diff_ext;
  logic        [SAMPLE_W:0]   mag_v, mag_m;

  always_comb begin
    sum_base = ctl.clear ? '0 : sum_r;
    max_base = ctl.clear ? '0 : max_r;
    sum_nxt  = sum_base + SUM_W'(raw);
    max_nxt  = (raw > max_base) ? raw : max_base;
    sum_shr  = sum_nxt >>> SUM_SHIFT;
    off_nxt  = ctl.done ? sum_shr[SAMPLE_W-1:0] : off_r;
  end

  // deadband: magnitude of -32768 is taken as 32768, maxima never negative
  always_comb begin
    diff     = raw - off_r;
    diff_ext = (SAMPLE_W+1)'(diff);
    mag_v    = diff_ext[SAMPLE_W] ? (SAMPLE_W+1)'(-diff_ext) : diff_ext;
    mag_m    = {1'b0, max_r};
    if (!ctl.meas || (mag_v < mag_m)) begin
      res = '0;
    end else begin
      res = diff;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      max_r <= '0;
      off_r <= '0;
    end else if (ctl.cal_en) begin
      sum_r <= sum_nxt;
      max_r <= max_nxt;
      off_r <= off_nxt;
    end
  end

endmodule
